/* design/assert_macros.svh */
// Assertion macros shared by the capped growth path payoff RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CGP_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
`define CGP_NEVER(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) !(prop)) \
      else $error("forbidden condition seen");
`else
`define CGP_ASSERT(label, clk, rst, prop)
`define CGP_NEVER(label, clk, rst, prop)
`endif
`endif

/* design/cgp_pkg.sv */
// Package for the capped growth path payoff block: constants, codes and types.
// Used by every module and interface of the block; depends on nothing.
`default_nettype none
package cgp_pkg;
   localparam int SampleWidth = 16;
   localparam int CsrIndexWidth = 2;
   localparam int CsrDataWidth = 25;
   localparam int PvWidth = 32;

   localparam logic [CsrIndexWidth-1:0] CSR_DRIFT = 2'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_VOL = 2'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_CAP = 2'd2;
   localparam logic [CsrIndexWidth-1:0] CSR_DISCOUNT = 2'd3;

   localparam logic [23:0] DRIFT_RESET = 24'd69905;
   localparam logic [22:0] VOL_RESET = 23'd484327;
   localparam logic [23:0] CAP_RESET = 24'd838861;
   localparam logic [24:0] DISCOUNT_RESET = 25'd14440065;

   localparam logic [24:0] LOG2E_Q24 = 25'd24204406;
   localparam logic [29:0] LN2_Q30 = 30'd744261118;
   localparam logic [31:0] ONE_Q30 = 32'h4000_0000;
   localparam logic [39:0] ONE_Q32 = 40'h01_0000_0000;
   localparam logic [39:0] PRODUCT_MAX = 40'hFF_FFFF_FFFF;
   localparam logic [2:0] TERM_COUNT = 3'd6;
   localparam logic [6:0] LEFT_SHIFT_MAX = 7'd20;

   typedef enum logic [4:0] {
      ST_IDLE, ST_VV, ST_VS, ST_E, ST_Y, ST_R, ST_R2, ST_AR, ST_DIV, ST_ACC,
      ST_FAC, ST_PL, ST_PH, ST_PS, ST_OL, ST_OH, ST_OS
   } state_type;

   typedef enum logic [4:0] {
      OP_NONE, OP_LATCH, OP_VV, OP_VS, OP_E, OP_Y, OP_R, OP_R2, OP_AR, OP_DIV,
      OP_ACC, OP_FAC, OP_PL, OP_PH, OP_PS, OP_OL, OP_OH, OP_OS
   } op_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic last_month;
      logic loop_done;
      logic rsp_free;
   } status_type;

   // Reciprocal multiplier for exact floor(q / n), q below 2^32.
   function automatic logic [32:0] div_mult(input logic [2:0] n);
      logic [32:0] m;
      case (n)
         3'd3, 3'd6: m = 33'h0_AAAA_AAAB;
         3'd5: m = 33'h0_CCCC_CCCD;
         default: m = 33'h1_0000_0000;
      endcase
      return m;
   endfunction

   function automatic logic [5:0] div_shift(input logic [2:0] n);
      logic [5:0] s;
      case (n)
         3'd2, 3'd3: s = 6'd33;
         3'd4, 3'd5, 3'd6: s = 6'd34;
         default: s = 6'd32;
      endcase
      return s;
   endfunction
endpackage
`default_nettype wire

/* design/cgp_ifs.sv */
// Request and response channel interfaces of the capped growth path payoff block.
// Depends on cgp_pkg for field widths.
`default_nettype none
interface cgp_req_if;
   logic valid;
   logic ready;
   logic signed [cgp_pkg::SampleWidth-1:0] normal_sample;
   logic last_month;
   modport source (output valid, output normal_sample, output last_month, input ready);
   modport sink (input valid, input normal_sample, input last_month, output ready);
endinterface

interface cgp_rsp_if;
   logic valid;
   logic ready;
   logic [cgp_pkg::PvWidth-1:0] present_value;
   logic overflowed;
   modport source (output valid, output present_value, output overflowed, input ready);
   modport sink (input valid, input present_value, input overflowed, output ready);
endinterface
`default_nettype wire

/* design/cgp_ctrl.sv */
// Sequencer of the capped growth path payoff block: steps one request through the datapath.
// Depends on cgp_pkg for the state, command and status types.
`default_nettype none
module cgp_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire cgp_pkg::status_type status,
   output cgp_pkg::cmd_type        cmd
);
   cgp_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cgp_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         cgp_pkg::ST_IDLE: if (req_valid) state_in = cgp_pkg::ST_VV;
         cgp_pkg::ST_VV: state_in = cgp_pkg::ST_VS;
         cgp_pkg::ST_VS: state_in = cgp_pkg::ST_E;
         cgp_pkg::ST_E: state_in = cgp_pkg::ST_Y;
         cgp_pkg::ST_Y: state_in = cgp_pkg::ST_R;
         cgp_pkg::ST_R: state_in = cgp_pkg::ST_R2;
         cgp_pkg::ST_R2: state_in = cgp_pkg::ST_AR;
         cgp_pkg::ST_AR: state_in = cgp_pkg::ST_DIV;
         cgp_pkg::ST_DIV: state_in = cgp_pkg::ST_ACC;
         cgp_pkg::ST_ACC: begin
            state_in = status.loop_done ? cgp_pkg::ST_FAC : cgp_pkg::ST_AR;
         end
         cgp_pkg::ST_FAC: state_in = cgp_pkg::ST_PL;
         cgp_pkg::ST_PL: state_in = cgp_pkg::ST_PH;
         cgp_pkg::ST_PH: state_in = cgp_pkg::ST_PS;
         cgp_pkg::ST_PS: begin
            state_in = status.last_month ? cgp_pkg::ST_OL : cgp_pkg::ST_IDLE;
         end
         cgp_pkg::ST_OL: state_in = cgp_pkg::ST_OH;
         cgp_pkg::ST_OH: state_in = cgp_pkg::ST_OS;
         cgp_pkg::ST_OS: if (status.rsp_free) state_in = cgp_pkg::ST_IDLE;
         default: state_in = cgp_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      cmd.op = cgp_pkg::OP_NONE;
      unique case (state_ff)
         cgp_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) cmd.op = cgp_pkg::OP_LATCH;
         end
         cgp_pkg::ST_VV: cmd.op = cgp_pkg::OP_VV;
         cgp_pkg::ST_VS: cmd.op = cgp_pkg::OP_VS;
         cgp_pkg::ST_E: cmd.op = cgp_pkg::OP_E;
         cgp_pkg::ST_Y: cmd.op = cgp_pkg::OP_Y;
         cgp_pkg::ST_R: cmd.op = cgp_pkg::OP_R;
         cgp_pkg::ST_R2: cmd.op = cgp_pkg::OP_R2;
         cgp_pkg::ST_AR: cmd.op = cgp_pkg::OP_AR;
         cgp_pkg::ST_DIV: cmd.op = cgp_pkg::OP_DIV;
         cgp_pkg::ST_ACC: cmd.op = cgp_pkg::OP_ACC;
         cgp_pkg::ST_FAC: cmd.op = cgp_pkg::OP_FAC;
         cgp_pkg::ST_PL: cmd.op = cgp_pkg::OP_PL;
         cgp_pkg::ST_PH: cmd.op = cgp_pkg::OP_PH;
         cgp_pkg::ST_PS: cmd.op = cgp_pkg::OP_PS;
         cgp_pkg::ST_OL: cmd.op = cgp_pkg::OP_OL;
         cgp_pkg::ST_OH: cmd.op = cgp_pkg::OP_OH;
         cgp_pkg::ST_OS: if (status.rsp_free) cmd.op = cgp_pkg::OP_OS;
         default: cmd.op = cgp_pkg::OP_NONE;
      endcase
   end
endmodule
`default_nettype wire

/* design/cgp_datapath.sv */
// Datapath of the capped growth path payoff block: registers, one shared multiplier,
// exponential series, running product and response register. Depends on cgp_pkg.
`default_nettype none
`include "assert_macros.svh"
module cgp_datapath (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire cgp_pkg::cmd_type                       cmd,
   output cgp_pkg::status_type                         status,
   input  wire logic                                   csr_we,
   input  wire logic [cgp_pkg::CsrIndexWidth-1:0]      csr_index,
   input  wire logic [cgp_pkg::CsrDataWidth-1:0]       csr_wdata,
   input  wire logic signed [cgp_pkg::SampleWidth-1:0] req_normal_sample,
   input  wire logic                                   req_last_month,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_ready,
   output logic [cgp_pkg::PvWidth-1:0]                 rsp_present_value,
   output logic                                        rsp_overflowed
);
   logic [23:0] drift_ff;
   logic [22:0] vol_ff;
   logic [23:0] cap_ff;
   logic [24:0] disc_ff;
   logic [15:0] sample_ff;
   logic last_ff;
   logic signed [67:0] mp_ff, mp_in;
   logic signed [33:0] mul_a, mul_b;
   logic [20:0] hv_ff;
   logic [28:0] e_ff, e_in;
   logic [5:0] k_ff;
   logic [29:0] r_ff;
   logic [31:0] acc_ff, acc_in;
   logic [2:0] n_ff;
   logic [32:0] fac_ff, fac_in;
   logic [52:0] plo_ff;
   logic [39:0] prod_ff;
   logic sat_ff;
   logic rsp_valid_ff;
   logic [31:0] pv_ff;
   logic ovf_ff;
   logic [64:0] quo_full;
   logic [6:0] sh;
   logic [6:0] rsh;
   logic [6:0] lsh;
   logic [51:0] fac_wide;
   logic [32:0] cap_q32;
   logic [73:0] sum_full;
   logic [41:0] sum_q;
   logic [39:0] payoff;

   assign cap_q32 = {1'b1, cap_ff, 8'h00};
   assign payoff = (prod_ff < cgp_pkg::ONE_Q32) ? cgp_pkg::ONE_Q32 : prod_ff;

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.op)
         cgp_pkg::OP_VV: begin
            mul_a = $signed({11'b0, vol_ff});
            mul_b = $signed({11'b0, vol_ff});
         end
         cgp_pkg::OP_VS: begin
            mul_a = $signed({11'b0, vol_ff});
            mul_b = $signed({{18{sample_ff[15]}}, sample_ff});
         end
         cgp_pkg::OP_Y: begin
            mul_a = $signed({{5{e_ff[28]}}, e_ff});
            mul_b = $signed({9'b0, cgp_pkg::LOG2E_Q24});
         end
         cgp_pkg::OP_R: begin
            mul_a = $signed({10'b0, mp_ff[47:24]});
            mul_b = $signed({4'b0, cgp_pkg::LN2_Q30});
         end
         cgp_pkg::OP_AR: begin
            mul_a = $signed({2'b0, acc_ff});
            mul_b = $signed({4'b0, r_ff});
         end
         cgp_pkg::OP_DIV: begin
            mul_a = $signed({2'b0, mp_ff[61:30]});
            mul_b = $signed({1'b0, cgp_pkg::div_mult(n_ff)});
         end
         cgp_pkg::OP_PL: begin
            mul_a = $signed({14'b0, prod_ff[19:0]});
            mul_b = $signed({1'b0, fac_ff});
         end
         cgp_pkg::OP_PH: begin
            mul_a = $signed({14'b0, prod_ff[39:20]});
            mul_b = $signed({1'b0, fac_ff});
         end
         cgp_pkg::OP_OL: begin
            mul_a = $signed({14'b0, payoff[19:0]});
            mul_b = $signed({9'b0, disc_ff});
         end
         cgp_pkg::OP_OH: begin
            mul_a = $signed({14'b0, payoff[39:20]});
            mul_b = $signed({9'b0, disc_ff});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      mp_in = mul_a * mul_b;
   end

   always_comb begin
      e_in = 29'($signed({{5{drift_ff[23]}}, drift_ff}) - $signed({8'b0, hv_ff})
             + $signed({{2{mp_ff[38]}}, mp_ff[38:12]}));
      quo_full = 65'(mp_ff[64:0] >> cgp_pkg::div_shift(n_ff));
      acc_in = cgp_pkg::ONE_Q30 + quo_full[31:0];
      sh = {k_ff[5], k_ff} + 7'd2;
      rsh = 7'(-sh);
      lsh = (sh > cgp_pkg::LEFT_SHIFT_MAX) ? cgp_pkg::LEFT_SHIFT_MAX : sh;
      if (sh[6]) begin
         fac_wide = {20'b0, acc_ff} >> rsh[5:0];
      end else begin
         fac_wide = {20'b0, acc_ff} << lsh[4:0];
      end
      fac_in = (fac_wide > {19'b0, cap_q32}) ? cap_q32 : fac_wide[32:0];
      sum_full = {1'b0, mp_ff[52:0], 20'b0} + {21'b0, plo_ff};
      sum_q = sum_full[73:32];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         drift_ff <= cgp_pkg::DRIFT_RESET;
         vol_ff <= cgp_pkg::VOL_RESET;
         cap_ff <= cgp_pkg::CAP_RESET;
         disc_ff <= cgp_pkg::DISCOUNT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            cgp_pkg::CSR_DRIFT: drift_ff <= csr_wdata[23:0];
            cgp_pkg::CSR_VOL: vol_ff <= csr_wdata[22:0];
            cgp_pkg::CSR_CAP: cap_ff <= csr_wdata[23:0];
            cgp_pkg::CSR_DISCOUNT: disc_ff <= csr_wdata;
            default: drift_ff <= drift_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_ff <= cgp_pkg::ONE_Q32;
         sat_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         n_ff <= cgp_pkg::TERM_COUNT;
      end else begin
         if (cmd.op == cgp_pkg::OP_OS) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (cmd.op == cgp_pkg::OP_R2) begin
            n_ff <= cgp_pkg::TERM_COUNT;
         end else if (cmd.op == cgp_pkg::OP_ACC) begin
            n_ff <= n_ff - 3'd1;
         end
         if (cmd.op == cgp_pkg::OP_PS) begin
            if (sum_q > {2'b0, cgp_pkg::PRODUCT_MAX}) begin
               prod_ff <= cgp_pkg::PRODUCT_MAX;
               sat_ff <= 1'b1;
            end else begin
               prod_ff <= sum_q[39:0];
            end
         end else if (cmd.op == cgp_pkg::OP_OS) begin
            prod_ff <= cgp_pkg::ONE_Q32;
            sat_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op != cgp_pkg::OP_NONE) begin
         mp_ff <= mp_in;
      end
      case (cmd.op)
         cgp_pkg::OP_LATCH: begin
            sample_ff <= req_normal_sample;
            last_ff <= req_last_month;
         end
         cgp_pkg::OP_VS: hv_ff <= mp_ff[45:25];
         cgp_pkg::OP_E: e_ff <= e_in;
         cgp_pkg::OP_R: k_ff <= mp_ff[53:48];
         cgp_pkg::OP_R2: begin
            r_ff <= mp_ff[53:24];
            acc_ff <= cgp_pkg::ONE_Q30;
         end
         cgp_pkg::OP_ACC: acc_ff <= acc_in;
         cgp_pkg::OP_FAC: fac_ff <= fac_in;
         cgp_pkg::OP_PH, cgp_pkg::OP_OH: plo_ff <= mp_ff[52:0];
         cgp_pkg::OP_OS: begin
            pv_ff <= (sum_q > 42'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum_q[31:0];
            ovf_ff <= sat_ff;
         end
         default: begin
         end
      endcase
   end

   assign status.last_month = last_ff;
   assign status.loop_done = (n_ff == 3'd1);
   assign status.rsp_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_present_value = pv_ff;
   assign rsp_overflowed = ovf_ff;

   `CGP_ASSERT(a_fac_capped, clock, reset, cmd.op == cgp_pkg::OP_FAC |=> fac_ff <= cap_q32)
   `CGP_ASSERT(a_path_restart, clock, reset, cmd.op == cgp_pkg::OP_OS |=> (prod_ff == cgp_pkg::ONE_Q32 && !sat_ff && rsp_valid_ff))
   `CGP_NEVER(a_loop_count, clock, reset, cmd.op == cgp_pkg::OP_ACC && (n_ff == 3'd0 || n_ff > cgp_pkg::TERM_COUNT))
endmodule
`default_nettype wire

/* design/capped_growth_path_payoff.sv */
// Top level of the capped growth path payoff block: sequencer plus datapath.
// Depends on cgp_pkg, cgp_ifs (channel interfaces), cgp_ctrl and cgp_datapath.
//
//   channel  direction  fields
//   req_ch   in         normal_sample (s16 Q3.12), last_month
//   rsp_ch   out        present_value (u32 Q8.24), overflowed
//   csr_*    in         csr_we, csr_index (2), csr_wdata (25)
//
// A request occupies the sequencer from its acceptance until it is idle again, and the
// shared multiplier sequences every product, six terms of the series among them.
// Reset is synchronous and restores the configuration registers, the response valid flag
// and a product of 1.0. A response waits in its own register; the next request is accepted
// meanwhile and only a last-month request stalls until that register is free.
`default_nettype none
module capped_growth_path_payoff (
   input  wire logic                                clock,
   input  wire logic                                reset,
   cgp_req_if.sink                                  req_ch,
   cgp_rsp_if.source                                rsp_ch,
   input  wire logic                                csr_we,
   input  wire logic [cgp_pkg::CsrIndexWidth-1:0]   csr_index,
   input  wire logic [cgp_pkg::CsrDataWidth-1:0]    csr_wdata
);
   cgp_pkg::cmd_type cmd;
   cgp_pkg::status_type status;
   logic req_ready;
   logic rsp_valid;
   logic [cgp_pkg::PvWidth-1:0] rsp_present_value;
   logic rsp_overflowed;

   cgp_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_valid(req_ch.valid),
      .req_ready(req_ready),
      .status(status),
      .cmd(cmd)
   );

   cgp_datapath u_datapath (
      .clock(clock),
      .reset(reset),
      .cmd(cmd),
      .status(status),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .req_normal_sample(req_ch.normal_sample),
      .req_last_month(req_ch.last_month),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ch.ready),
      .rsp_present_value(rsp_present_value),
      .rsp_overflowed(rsp_overflowed)
   );

   assign req_ch.ready = req_ready;
   assign rsp_ch.valid = rsp_valid;
   assign rsp_ch.present_value = rsp_present_value;
   assign rsp_ch.overflowed = rsp_overflowed;
endmodule
`default_nettype wire

/* verif/capped_growth_path_payoff_test.sv */
// Testbench for the capped growth path payoff block: directed and random monthly samples in paths.
// Uses cgp_pkg, the cgp_req_if / cgp_rsp_if channel interfaces and the block itself.
// A built-in payoff model predicts each present value and overflow flag, which the monitor compares.
`timescale 1ns / 100ps
`default_nettype none
module capped_growth_path_payoff_test;
   typedef struct {
      logic signed [15:0] sample;
      logic               last;
   } month_type;

   typedef struct {
      logic [31:0] pv;
      logic        ovf;
   } payoff_type;

   logic clock;
   logic reset;
   logic csr_we;
   logic [cgp_pkg::CsrIndexWidth-1:0] csr_index;
   logic [cgp_pkg::CsrDataWidth-1:0] csr_wdata;

   cgp_req_if req_ch ();
   cgp_rsp_if rsp_ch ();

   capped_growth_path_payoff dut (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   month_type  pending_months[$];
   payoff_type expected_payoffs[$];
   int         error_count = 0;
   int         accepted_months = 0;
   int         cycle_count = 0;
   bit         no_idle = 0;
   bit         hold_rsp = 0;

   longint drift_q24;
   longint vol_q24;
   longint unsigned cap_q24;
   longint unsigned discount_q24;
   logic [39:0] path_product;
   logic        path_saturated;

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   function automatic logic [63:0] mul_q32(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      return p[95:32];
   endfunction

   function automatic logic [63:0] growth_factor_q32(input logic signed [15:0] s);
      longint hv, vs, e, y, k, sh;
      longint unsigned f, r, acc;
      hv = (vol_q24 * vol_q24) >>> 25;
      vs = (vol_q24 * longint'(s)) >>> 12;
      e = drift_q24 - hv + vs;
      y = (e * 64'sd24204406) >>> 24;
      k = y >>> 24;
      f = longint'(y - (k <<< 24));
      r = (f * 64'd744261118) >> 24;
      acc = 64'd1 << 30;
      for (int n = 6; n >= 1; n--) begin
         acc = (64'd1 << 30) + ((acc * r) >> 30) / longint'(n);
      end
      sh = k + 2;
      if (sh >= 0) begin
         if (sh > 20) sh = 20;
         return acc << sh;
      end
      if (-sh >= 40) return 64'd0;
      return acc >> (-sh);
   endfunction

   // Advances the path by one month; returns 1 when a payoff comes out.
   function automatic bit advance_month(input month_type m, output payoff_type po);
      logic [63:0] factor, cap, prod, payoff, pv;
      factor = growth_factor_q32(m.sample);
      cap = (64'd1 << 32) + (cap_q24 << 8);
      if (factor > cap) factor = cap;
      prod = mul_q32({24'd0, path_product}, factor);
      if (prod > 64'hFF_FFFF_FFFF) begin
         prod = 64'hFF_FFFF_FFFF;
         path_saturated = 1'b1;
      end
      path_product = prod[39:0];
      po.pv = '0;
      po.ovf = 1'b0;
      if (!m.last) return 1'b0;
      payoff = (prod < (64'd1 << 32)) ? (64'd1 << 32) : prod;
      pv = mul_q32(payoff, discount_q24);
      if (pv > 64'hFFFF_FFFF) pv = 64'hFFFF_FFFF;
      po.pv = pv[31:0];
      po.ovf = path_saturated;
      path_product = 40'h01_0000_0000;
      path_saturated = 1'b0;
      return 1'b1;
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("MISMATCH %s: got %0d, expected %0d at cycle %0d", what, got, want, cycle_count);
      error_count++;
   endtask

   // Request driver.
   always @(posedge clock) begin
      payoff_type po;
      month_type  m;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            m.sample = req_ch.normal_sample;
            m.last = req_ch.last_month;
            if (advance_month(m, po)) expected_payoffs.push_back(po);
            accepted_months++;
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (pending_months.size() > 0 && (no_idle || $urandom_range(99) >= 28)) begin
               m = pending_months.pop_front();
               req_ch.valid <= 1'b1;
               req_ch.normal_sample <= m.sample;
               req_ch.last_month <= m.last;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor.
   always @(posedge clock) begin
      payoff_type want;
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_payoffs.size() == 0) begin
               report_mismatch("unexpected response", rsp_ch.present_value, -1);
            end else begin
               want = expected_payoffs.pop_front();
               if (rsp_ch.present_value !== want.pv)
                  report_mismatch("present_value", rsp_ch.present_value, want.pv);
               if (rsp_ch.overflowed !== want.ovf)
                  report_mismatch("overflowed", rsp_ch.overflowed, want.ovf);
            end
         end
      end
      rsp_ch.ready <= !hold_rsp && (no_idle || $urandom_range(99) >= 28);
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > 800000) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // The receiver holds off for a long stretch so the block backs up.
   initial begin
      wait (accepted_months >= 300);
      @(posedge clock);
      hold_rsp = 1'b1;
      repeat (500) @(posedge clock);
      hold_rsp = 1'b0;
   end

   task automatic write_csr(input logic [cgp_pkg::CsrIndexWidth-1:0] idx,
                            input logic [24:0] data);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         cgp_pkg::CSR_DRIFT: drift_q24 = longint'($signed(data[23:0]));
         cgp_pkg::CSR_VOL: vol_q24 = longint'(data[22:0]);
         cgp_pkg::CSR_CAP: cap_q24 = data[23:0];
         cgp_pkg::CSR_DISCOUNT: discount_q24 = data;
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic set_config(input logic [24:0] d, input logic [24:0] v,
                             input logic [24:0] c, input logic [24:0] df);
      write_csr(cgp_pkg::CSR_DRIFT, d);
      write_csr(cgp_pkg::CSR_VOL, v);
      write_csr(cgp_pkg::CSR_CAP, c);
      write_csr(cgp_pkg::CSR_DISCOUNT, df);
   endtask

   task automatic wait_idle();
      while (pending_months.size() > 0 || req_ch.valid || expected_payoffs.size() > 0)
         @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic push_month(input logic signed [15:0] s, input logic last);
      month_type m;
      m.sample = s;
      m.last = last;
      pending_months.push_back(m);
   endtask

   task automatic queue_paths(input int count);
      int left, len;
      logic signed [15:0] s;
      left = count;
      while (left > 0) begin
         len = ($urandom_range(9) == 0) ? $urandom_range(60, 25) : $urandom_range(24, 1);
         if (len > left) len = left;
         for (int i = 0; i < len; i++) begin
            if ($urandom_range(9) == 0)
               s = 16'($urandom);
            else
               s = 16'($urandom_range(4096) + $urandom_range(4096) + $urandom_range(4096)
                   + $urandom_range(4096) - 8192);
            push_month(s, i == len - 1);
         end
         left -= len;
      end
   endtask

   initial begin
      req_ch.valid = 1'b0;
      req_ch.normal_sample = '0;
      req_ch.last_month = 1'b0;
      rsp_ch.ready = 1'b0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      reset = 1'b1;
      drift_q24 = 69905;
      vol_q24 = 484327;
      cap_q24 = 838861;
      discount_q24 = 14440065;
      path_product = 40'h01_0000_0000;
      path_saturated = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed months at the reset settings.
      push_month(16'sh7FFF, 1'b1);
      push_month(-16'sh8000, 1'b1);
      push_month(16'sd0, 1'b1);
      push_month(-16'sd1, 1'b0);
      push_month(16'sd1, 1'b1);
      push_month(16'sh5555, 1'b0);
      push_month(-16'sh5556, 1'b1);
      wait_idle();
      // Large cap and growth so the product saturates, discount above one.
      set_config(25'h7F_FFFF, 25'h7F_FFFF, 25'hFF_FFFF, 25'h1FF_FFFF);
      for (int i = 0; i < 11; i++) push_month(16'sh7FFF, i == 10);
      push_month(16'sh7FFF, 1'b0);
      push_month(-16'sh8000, 1'b1);
      wait_idle();
      // Zero cap, zero volatility, zero discount, most negative drift.
      set_config(25'h80_0000, 25'd0, 25'd0, 25'd0);
      push_month(16'sh7FFF, 1'b1);
      push_month(-16'sh8000, 1'b0);
      push_month(16'sd0, 1'b1);
      wait_idle();

      set_config(25'd69905, 25'd484327, 25'd838861, 25'd14440065);
      no_idle = 1'b1;
      queue_paths(250);
      wait_idle();
      no_idle = 1'b0;
      queue_paths(350);
      wait_idle();
      set_config(25'h7F_FFFF, 25'h7F_FFFF, 25'hFF_FFFF, 25'd16777216);
      queue_paths(250);
      wait_idle();
      set_config(25'h80_0000, 25'h7F_FFFF, 25'd0, 25'h1FF_FFFF);
      queue_paths(250);
      wait_idle();
      for (int p = 0; p < 3; p++) begin
         set_config(25'($urandom), 25'($urandom), 25'($urandom), 25'($urandom));
         queue_paths(250);
         wait_idle();
      end

      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end
endmodule
`default_nettype wire
